// ===== design/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared widths, register indexes and stage types for the lidar projector.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int P_W    = 24;  // point coordinate
  localparam int Q_W    = 16;  // quaternion part, Q2.14
  localparam int QF     = 14;  // quaternion fraction bits
  localparam int T_W    = 42;  // t = 2*(q x p)
  localparam int VT_W   = 60;  // q x t and w*t
  localparam int ACC_W  = 62;  // rotation accumulator
  localparam int PC_W   = 34;  // camera frame point
  localparam int K_W    = 21;  // camera entry / translation part
  localparam int N_W    = 58;  // K*p' component
  localparam int AN_W   = 58;  // magnitude of a component
  localparam int R_W    = 59;  // division remainder (2*|num|)
  localparam int QB     = 18;  // quotient bits of floor(2*|num|/|den|)
  localparam int CMP_W  = 77;  // R_W + QB
  localparam int PIX_W  = 16;
  localparam int DIM_W  = 13;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_QUAT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRANS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW0   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic [63:0] QUAT_RST  = 64'h4000_0000_0000_0000;
  localparam logic [62:0] ROW0_RST  = 63'(64'd1 << 50);
  localparam logic [62:0] ROW1_RST  = 63'(64'd1 << 29);
  localparam logic [62:0] ROW2_RST  = 63'(64'd1 << 8);
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd1080;

  // Division stage payload, both lanes share the denominator.
  typedef struct packed {
    logic [R_W-1:0]  rem_u;
    logic [R_W-1:0]  rem_v;
    logic [QB-1:0]   q_u;
    logic [QB-1:0]   q_v;
    logic            sat_u;
    logic            sat_v;
    logic            neg_u;
    logic            neg_v;
    logic            nz_u;   // numerator is zero
    logic            nz_v;
    logic            zero;   // denominator is zero
    logic [AN_W-1:0] ad;
  } div_t;

endpackage

// ===== design/lpp_rotate.sv =====
// ----------------------------------------------------------------------------
// lpp_rotate
// Quaternion rotation plus translation, three register stages.
// ----------------------------------------------------------------------------
module lpp_rotate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [lpp_pkg::P_W-1:0]    p_x_i,
  input  logic signed [lpp_pkg::P_W-1:0]    p_y_i,
  input  logic signed [lpp_pkg::P_W-1:0]    p_z_i,
  input  logic [63:0]                       quat_i,
  input  logic [62:0]                       trans_i,
  output logic                              vld_o,
  output logic signed [lpp_pkg::PC_W-1:0]   pc_x_o,
  output logic signed [lpp_pkg::PC_W-1:0]   pc_y_o,
  output logic signed [lpp_pkg::PC_W-1:0]   pc_z_o
);

  localparam int T_W   = lpp_pkg::T_W;
  localparam int VT_W  = lpp_pkg::VT_W;
  localparam int ACC_W = lpp_pkg::ACC_W;
  localparam int PC_W  = lpp_pkg::PC_W;
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (2*lpp_pkg::QF-1);

  logic signed [lpp_pkg::Q_W-1:0] w, qv [3];
  logic signed [lpp_pkg::K_W-1:0] tr [3];
  logic signed [lpp_pkg::P_W-1:0] p [3];

  logic [2:0] vld_q;
  logic signed [lpp_pkg::P_W-1:0] p1_q [3];
  logic signed [lpp_pkg::P_W-1:0] p2_q [3];
  logic signed [T_W-1:0]  t_d  [3], t_q  [3];
  logic signed [VT_W-1:0] vt_d [3], vt_q [3];
  logic signed [VT_W-1:0] wt_d [3], wt_q [3];
  logic signed [PC_W-1:0] pc_d [3], pc_q [3];
  logic signed [ACC_W-1:0] acc [3];

  assign w     = quat_i[63:48];
  assign qv[0] = quat_i[47:32];
  assign qv[1] = quat_i[31:16];
  assign qv[2] = quat_i[15:0];
  assign tr[0] = trans_i[62:42];
  assign tr[1] = trans_i[41:21];
  assign tr[2] = trans_i[20:0];
  assign p[0]  = p_x_i;
  assign p[1]  = p_y_i;
  assign p[2]  = p_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = (T_W'(qv[(i+1)%3]) * T_W'(p[(i+2)%3]) -
                T_W'(qv[(i+2)%3]) * T_W'(p[(i+1)%3])) <<< 1;
      vt_d[i] = VT_W'(qv[(i+1)%3]) * VT_W'(t_q[(i+2)%3]) -
                VT_W'(qv[(i+2)%3]) * VT_W'(t_q[(i+1)%3]);
      wt_d[i] = VT_W'(w) * VT_W'(t_q[i]);
      acc[i]  = (ACC_W'(p2_q[i]) <<< (2*lpp_pkg::QF)) + ACC_W'(wt_q[i]) +
                ACC_W'(vt_q[i]) + ROUND_C;
      pc_d[i] = PC_W'(acc[i] >>> (2*lpp_pkg::QF)) + PC_W'(tr[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p;
      t_q  <= t_d;
      p2_q <= p1_q;
      vt_q <= vt_d;
      wt_q <= wt_d;
      pc_q <= pc_d;
    end
  end

  assign vld_o  = vld_q[2];
  assign pc_x_o = pc_q[0];
  assign pc_y_o = pc_q[1];
  assign pc_z_o = pc_q[2];

endmodule

// ===== design/lpp_camera.sv =====
// ----------------------------------------------------------------------------
// lpp_camera
// Camera matrix product: products stage, then row sums.
// ----------------------------------------------------------------------------
module lpp_camera (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic signed [lpp_pkg::PC_W-1:0]  pc_x_i,
  input  logic signed [lpp_pkg::PC_W-1:0]  pc_y_i,
  input  logic signed [lpp_pkg::PC_W-1:0]  pc_z_i,
  input  logic [62:0]                      row0_i,
  input  logic [62:0]                      row1_i,
  input  logic [62:0]                      row2_i,
  output logic                             vld_o,
  output logic signed [lpp_pkg::N_W-1:0]   nu_o,
  output logic signed [lpp_pkg::N_W-1:0]   nv_o,
  output logic signed [lpp_pkg::N_W-1:0]   den_o
);

  localparam int N_W = lpp_pkg::N_W;

  logic [62:0] row [3];
  logic signed [lpp_pkg::PC_W-1:0] pc [3];
  logic signed [lpp_pkg::K_W-1:0] k [3][3];
  logic signed [N_W-1:0] prod_d [3][3], prod_q [3][3];
  logic signed [N_W-1:0] sum_d [3], sum_q [3];
  logic [1:0] vld_q;

  assign row[0] = row0_i;
  assign row[1] = row1_i;
  assign row[2] = row2_i;
  assign pc[0]  = pc_x_i;
  assign pc[1]  = pc_y_i;
  assign pc[2]  = pc_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      k[r][0] = row[r][62:42];
      k[r][1] = row[r][41:21];
      k[r][2] = row[r][20:0];
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = N_W'(k[r][c]) * N_W'(pc[c]);
      end
      sum_d[r] = prod_q[r][0] + prod_q[r][1] + prod_q[r][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign vld_o = vld_q[1];
  assign nu_o  = sum_q[0];
  assign nv_o  = sum_q[1];
  assign den_o = sum_q[2];

endmodule

// ===== design/lpp_divide.sv =====
// ----------------------------------------------------------------------------
// lpp_divide
// Two-lane pipelined restoring divider, one quotient bit per stage, then
// rounding, saturation and the image bounds test.
// ----------------------------------------------------------------------------
module lpp_divide (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [lpp_pkg::N_W-1:0]    nu_i,
  input  logic signed [lpp_pkg::N_W-1:0]    nv_i,
  input  logic signed [lpp_pkg::N_W-1:0]    den_i,
  input  logic [lpp_pkg::DIM_W-1:0]         width_i,
  input  logic [lpp_pkg::DIM_W-1:0]         height_i,
  output logic                              vld_o,
  output logic signed [lpp_pkg::PIX_W-1:0]  pixel_u_o,
  output logic signed [lpp_pkg::PIX_W-1:0]  pixel_v_o,
  output logic                              in_view_o,
  output logic                              zero_depth_o
);

  localparam int QB    = lpp_pkg::QB;
  localparam int R_W   = lpp_pkg::R_W;
  localparam int AN_W  = lpp_pkg::AN_W;
  localparam int CMP_W = lpp_pkg::CMP_W;
  localparam int PIX_W = lpp_pkg::PIX_W;
  localparam int NST   = QB + 2;  // setup, saturation check, QB bit steps

  lpp_pkg::div_t dq_q [NST];
  lpp_pkg::div_t dq_d [NST];
  logic [NST-1:0] vld_q;
  logic [AN_W-1:0] an_u, an_v;

  always_comb begin
    an_u = nu_i[lpp_pkg::N_W-1] ? AN_W'(-nu_i) : AN_W'(nu_i);
    an_v = nv_i[lpp_pkg::N_W-1] ? AN_W'(-nv_i) : AN_W'(nv_i);
    dq_d[0]       = '0;
    dq_d[0].rem_u = {an_u, 1'b0};
    dq_d[0].rem_v = {an_v, 1'b0};
    dq_d[0].neg_u = nu_i[lpp_pkg::N_W-1] != den_i[lpp_pkg::N_W-1];
    dq_d[0].neg_v = nv_i[lpp_pkg::N_W-1] != den_i[lpp_pkg::N_W-1];
    dq_d[0].nz_u  = (nu_i == '0);
    dq_d[0].nz_v  = (nv_i == '0);
    dq_d[0].zero  = (den_i == '0);
    dq_d[0].ad    = den_i[lpp_pkg::N_W-1] ? AN_W'(-den_i) : AN_W'(den_i);
  end

  // Quotient would need more than QB bits: result saturates.
  always_comb begin
    dq_d[1]       = dq_q[0];
    dq_d[1].sat_u = CMP_W'(dq_q[0].rem_u) >= (CMP_W'(dq_q[0].ad) << QB);
    dq_d[1].sat_v = CMP_W'(dq_q[0].rem_v) >= (CMP_W'(dq_q[0].ad) << QB);
  end

  for (genvar s = 2; s < NST; s++) begin : g_step
    localparam int K = NST - 1 - s;
    logic [CMP_W-1:0] cmp;
    always_comb begin
      cmp     = CMP_W'(dq_q[s-1].ad) << K;
      dq_d[s] = dq_q[s-1];
      if (CMP_W'(dq_q[s-1].rem_u) >= cmp) begin
        dq_d[s].rem_u  = dq_q[s-1].rem_u - R_W'(cmp);
        dq_d[s].q_u[K] = 1'b1;
      end
      if (CMP_W'(dq_q[s-1].rem_v) >= cmp) begin
        dq_d[s].rem_v  = dq_q[s-1].rem_v - R_W'(cmp);
        dq_d[s].q_v[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q <= dq_d;
    end
  end

  // Final stage: q2 = floor(2|n|/|d|); round = (q2+1)/2, floor = q2/2.
  lpp_pkg::div_t      f;
  logic [QB-1:0]      qr_u, qr_v;
  logic [QB-2:0]      fq_u, fq_v;
  logic               ex_u, ex_v, in_u, in_v;
  logic signed [PIX_W-1:0] pu_d, pv_d;
  logic               vld_out_q, inv_q, zd_q;
  logic signed [PIX_W-1:0] pu_q, pv_q;

  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
  localparam logic [QB-1:0] LIM_POS = QB'(PIX_MAX);
  localparam logic [QB-1:0] LIM_NEG = LIM_POS + QB'(1);

  always_comb begin
    f    = dq_q[NST-1];
    // one extra bit so an all-ones q2 rounds up instead of wrapping
    qr_u = QB'(({1'b0, f.q_u} + (QB+1)'(1)) >> 1);
    qr_v = QB'(({1'b0, f.q_v} + (QB+1)'(1)) >> 1);
    fq_u = f.q_u[QB-1:1];
    fq_v = f.q_v[QB-1:1];
    ex_u = !f.q_u[0] && (f.rem_u == '0);
    ex_v = !f.q_v[0] && (f.rem_v == '0);

    if (f.sat_u)                      pu_d = f.neg_u ? PIX_MIN : PIX_MAX;
    else if (f.neg_u && qr_u > LIM_NEG) pu_d = PIX_MIN;
    else if (f.neg_u)                 pu_d = PIX_W'(-qr_u);
    else if (qr_u > LIM_POS)          pu_d = PIX_MAX;
    else                              pu_d = PIX_W'(qr_u);

    if (f.sat_v)                      pv_d = f.neg_v ? PIX_MIN : PIX_MAX;
    else if (f.neg_v && qr_v > LIM_NEG) pv_d = PIX_MIN;
    else if (f.neg_v)                 pv_d = PIX_W'(-qr_v);
    else if (qr_v > LIM_POS)          pv_d = PIX_MAX;
    else                              pv_d = PIX_W'(qr_v);

    in_u = f.nz_u || (!f.neg_u && !f.sat_u &&
           (fq_u < (QB-1)'(width_i) || (fq_u == (QB-1)'(width_i) && ex_u)));
    in_v = f.nz_v || (!f.neg_v && !f.sat_v &&
           (fq_v < (QB-1)'(height_i) || (fq_v == (QB-1)'(height_i) && ex_v)));

    if (f.zero) begin
      pu_d = '0;
      pv_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pu_q  <= pu_d;
      pv_q  <= pv_d;
      inv_q <= in_u && in_v && !f.zero;
      zd_q  <= f.zero;
    end
  end

  assign vld_o        = vld_out_q;
  assign pixel_u_o    = pu_q;
  assign pixel_v_o    = pv_q;
  assign in_view_o    = inv_q;
  assign zero_depth_o = zd_q;

endmodule

// ===== design/lidar_point_to_pixel_projection.sv =====
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projection
// Rigid transform of a lidar point, camera matrix, perspective divide.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, point_x/y/z_i      | sink
//   out     | out_valid_o/out_ready_i, pixel_u/v_o, ... | source
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i           | write only
//
// One transfer per cycle in each direction while the output is not stalled;
// 3 rotation, 2 camera and 21 divider stages incl. output register, most
// of them in the one-bit-per-stage divider. The whole pipeline advances
// when the output register is empty or taken; a stall freezes every stage.
// Reset clears valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpp_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [lpp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lpp_pkg::P_W-1:0]    point_x_i,
  input  logic signed [lpp_pkg::P_W-1:0]    point_y_i,
  input  logic signed [lpp_pkg::P_W-1:0]    point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lpp_pkg::PIX_W-1:0]  pixel_u_o,
  output logic signed [lpp_pkg::PIX_W-1:0]  pixel_v_o,
  output logic                              in_view_o,
  output logic                              zero_depth_o
);

  logic [63:0] quat_q;
  logic [62:0] trans_q, row0_q, row1_q, row2_q;
  logic [lpp_pkg::DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q   <= lpp_pkg::QUAT_RST;
      trans_q  <= '0;
      row0_q   <= lpp_pkg::ROW0_RST;
      row1_q   <= lpp_pkg::ROW1_RST;
      row2_q   <= lpp_pkg::ROW2_RST;
      width_q  <= lpp_pkg::WIDTH_RST;
      height_q <= lpp_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpp_pkg::REG_QUAT:   quat_q   <= cfg_wdata_i;
        lpp_pkg::REG_TRANS:  trans_q  <= cfg_wdata_i[62:0];
        lpp_pkg::REG_ROW0:   row0_q   <= cfg_wdata_i[62:0];
        lpp_pkg::REG_ROW1:   row1_q   <= cfg_wdata_i[62:0];
        lpp_pkg::REG_ROW2:   row2_q   <= cfg_wdata_i[62:0];
        lpp_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[lpp_pkg::DIM_W-1:0];
        lpp_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[lpp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic rot_vld, cam_vld;
  logic signed [lpp_pkg::PC_W-1:0] pc_x, pc_y, pc_z;
  logic signed [lpp_pkg::N_W-1:0] nu, nv, den;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  lpp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .p_x_i   (point_x_i),
    .p_y_i   (point_y_i),
    .p_z_i   (point_z_i),
    .quat_i  (quat_q),
    .trans_i (trans_q),
    .vld_o   (rot_vld),
    .pc_x_o  (pc_x),
    .pc_y_o  (pc_y),
    .pc_z_o  (pc_z)
  );

  lpp_camera u_camera (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rot_vld),
    .pc_x_i (pc_x),
    .pc_y_i (pc_y),
    .pc_z_i (pc_z),
    .row0_i (row0_q),
    .row1_i (row1_q),
    .row2_i (row2_q),
    .vld_o  (cam_vld),
    .nu_o   (nu),
    .nv_o   (nv),
    .den_o  (den)
  );

  lpp_divide u_divide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (cam_vld),
    .nu_i         (nu),
    .nv_i         (nv),
    .den_i        (den),
    .width_i      (width_q),
    .height_i     (height_q),
    .vld_o        (out_valid_o),
    .pixel_u_o    (pixel_u_o),
    .pixel_v_o    (pixel_v_o),
    .in_view_o    (in_view_o),
    .zero_depth_o (zero_depth_o)
  );

endmodule
